[src/gnd_pkg.sv]
// Shared types, constants and arithmetic helpers for the gradient noise pipeline.
// Holds the permutation ROM, the gradient dot functions and the Q16.16 multiply.
// No dependencies.
package gnd_pkg;

	localparam int FracBits  = 16;
	localparam int CoordBits = 32;
	localparam int CellBits  = 8;
	localparam int OutBits   = 20;
	localparam int ValBits   = 24;

	// Working value: signed, wide enough for fades, corners and lerps
	typedef logic signed [ValBits-1:0] val_t;
	// Corner offset: fraction or fraction minus one
	typedef logic signed [FracBits+1:0] ofs_t;
	typedef logic signed [OutBits-1:0] corner_t;
	typedef logic [FracBits-1:0] frac_t;
	typedef logic [CellBits-1:0] cell_t;

	// Mode codes
	localparam logic MODE_2D = 1'b0;
	localparam logic MODE_3D = 1'b1;

	localparam val_t ONE      = val_t'(1 << FracBits);
	localparam val_t HALF     = val_t'(1 << (FracBits - 1));
	localparam val_t OUT_MAX  = val_t'(524287);
	localparam val_t OUT_MIN  = -val_t'(524288);

	// Load enables, one per pipeline stage
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic s7;
		logic s8;
	} stage_en_t;

	localparam cell_t PERM [256] = '{
		8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
		8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
		8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
		8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
		8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
		8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
		8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
		8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
		8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
		8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
		8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
		8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
		8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
		8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
		8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
		8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
		8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
		8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
		8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
		8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
		8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
		8'd215,8'd61,8'd156,8'd180};

	// Fixed-point product, half rounded up, floor shift
	function automatic val_t mulq(input val_t a, input val_t b);
		logic signed [2*ValBits-1:0] p;
		p = a * b + (2*ValBits)'(HALF);
		return p[FracBits+ValBits-1:FracBits];
	endfunction

	function automatic val_t lerp(input val_t t, input val_t a, input val_t b);
		val_t d;
		d = b - a;
		return a + mulq(t, d);
	endfunction

	// Eight 2D gradients
	function automatic corner_t grad2(input cell_t h, input ofs_t x, input ofs_t y);
		corner_t gx;
		corner_t gy;
		gx = OutBits'(x);
		gy = OutBits'(y);
		unique case (h[2:0])
			3'd0: return gx;
			3'd1: return -gx;
			3'd2: return gy;
			3'd3: return -gy;
			3'd4: return gx + gy;
			3'd5: return -gx + gy;
			3'd6: return gx - gy;
			default: return -gx - gy;
		endcase
	endfunction

	// Twelve 3D gradients; codes twelve to fifteen repeat the first four
	function automatic corner_t grad3(input cell_t h, input ofs_t x, input ofs_t y,
			input ofs_t z);
		corner_t gx;
		corner_t gy;
		corner_t gz;
		gx = OutBits'(x);
		gy = OutBits'(y);
		gz = OutBits'(z);
		unique case (h[3:0])
			4'd0, 4'd12: return gx + gy;
			4'd1, 4'd13: return -gx + gy;
			4'd2, 4'd14: return gx - gy;
			4'd3, 4'd15: return -gx - gy;
			4'd4: return gx + gz;
			4'd5: return -gx + gz;
			4'd6: return gx - gz;
			4'd7: return -gx - gz;
			4'd8: return gy + gz;
			4'd9: return -gy + gz;
			4'd10: return gy - gz;
			default: return -gy - gz;
		endcase
	endfunction

endpackage

[src/gnd_fade.sv]
// Four-stage fade curve 6f^6-15f^5+10f^4 for one axis.
// Depends on gnd_pkg.
module gnd_fade import gnd_pkg::*; (
	input  logic      clk,
	input  stage_en_t en,
	input  frac_t     frac_s1,
	output val_t      fade_s5
);

	val_t f_s2, q_s2, f2_s2;
	val_t f_s3, r_s3, f3_s3;
	val_t s_s4, f3_s4;
	val_t f1;

	assign f1 = val_t'(frac_s1);

	// Stage two: linear term and square
	always_ff @(posedge clk) begin
		if (en.s2) begin
			f_s2  <= f1;
			q_s2  <= val_t'(6) * f1 - val_t'(15) * ONE;
			f2_s2 <= mulq(f1, f1);
		end
	end

	// Stage three: quadratic term and cube
	always_ff @(posedge clk) begin
		if (en.s3) begin
			f_s3  <= f_s2;
			r_s3  <= mulq(f_s2, q_s2) + val_t'(10) * ONE;
			f3_s3 <= mulq(f2_s2, f_s2);
		end
	end

	// Stage four: cubic term
	always_ff @(posedge clk) begin
		if (en.s4) begin
			s_s4  <= mulq(f_s3, r_s3);
			f3_s4 <= f3_s3;
		end
	end

	// Stage five: combine
	always_ff @(posedge clk) begin
		if (en.s5) begin
			fade_s5 <= mulq(f3_s4, s_s4);
		end
	end

endmodule

[src/gnd_hash.sv]
// Lattice hashing through the permutation ROM and corner gradient dots.
// Three lookup stages and one dot stage. Depends on gnd_pkg.
module gnd_hash import gnd_pkg::*; (
	input  logic      clk,
	input  stage_en_t en,
	input  logic      mode_s1,
	input  cell_t     cx_s1,
	input  cell_t     cy_s1,
	input  cell_t     cz_s1,
	input  frac_t     fx_s1,
	input  frac_t     fy_s1,
	input  frac_t     fz_s1,
	output corner_t   corner_s5 [8]
);

	logic  mode_s2, mode_s3, mode_s4;
	cell_t cz_s2, cz_s3;
	cell_t a_s2, b_s2;
	cell_t p_s3 [4];
	cell_t h_s4 [8];
	frac_t fx_s2, fy_s2, fz_s2, fx_s3, fy_s3, fz_s3, fx_s4, fy_s4, fz_s4;
	cell_t row;
	cell_t aa, ab, ba, bb;

	// Stage two: first lookup on x
	assign row = (mode_s1 == MODE_3D) ? cy_s1 : cz_s1;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			a_s2    <= PERM[cx_s1] + row;
			b_s2    <= PERM[cell_t'(cx_s1 + 8'd1)] + row;
			cz_s2   <= cz_s1;
			mode_s2 <= mode_s1;
			fx_s2   <= fx_s1;
			fy_s2   <= fy_s1;
			fz_s2   <= fz_s1;
		end
	end

	// Stage three: second lookup; slots are a, a+1, b, b+1
	always_ff @(posedge clk) begin
		if (en.s3) begin
			p_s3[0] <= PERM[a_s2];
			p_s3[1] <= PERM[cell_t'(a_s2 + 8'd1)];
			p_s3[2] <= PERM[b_s2];
			p_s3[3] <= PERM[cell_t'(b_s2 + 8'd1)];
			cz_s3   <= cz_s2;
			mode_s3 <= mode_s2;
			fx_s3   <= fx_s2;
			fy_s3   <= fy_s2;
			fz_s3   <= fz_s2;
		end
	end

	// Stage four: third lookup in 3D; corner slot index is {x, y, z}
	assign aa = p_s3[0] + cz_s3;
	assign ab = p_s3[1] + cz_s3;
	assign ba = p_s3[2] + cz_s3;
	assign bb = p_s3[3] + cz_s3;

	always_ff @(posedge clk) begin
		if (en.s4) begin
			if (mode_s3 == MODE_3D) begin
				h_s4[0] <= PERM[aa];
				h_s4[1] <= PERM[cell_t'(aa + 8'd1)];
				h_s4[2] <= PERM[ab];
				h_s4[3] <= PERM[cell_t'(ab + 8'd1)];
				h_s4[4] <= PERM[ba];
				h_s4[5] <= PERM[cell_t'(ba + 8'd1)];
				h_s4[6] <= PERM[bb];
				h_s4[7] <= PERM[cell_t'(bb + 8'd1)];
			end else begin
				// 2D: the middle bit of the slot stands for z
				h_s4[0] <= p_s3[0];
				h_s4[1] <= '0;
				h_s4[2] <= p_s3[1];
				h_s4[3] <= '0;
				h_s4[4] <= p_s3[2];
				h_s4[5] <= '0;
				h_s4[6] <= p_s3[3];
				h_s4[7] <= '0;
			end
			mode_s4 <= mode_s3;
			fx_s4   <= fx_s3;
			fy_s4   <= fy_s3;
			fz_s4   <= fz_s3;
		end
	end

	// Stage five: gradient dots with corner offsets
	for (genvar k = 0; k < 8; k++) begin : g_corner
		localparam logic [2:0] Slot = 3'(k);
		ofs_t ox, oy, oz, oz2;
		assign ox  = (Slot[2] ? ofs_t'(fx_s4) - ofs_t'(ONE) : ofs_t'(fx_s4));
		assign oy  = (Slot[1] ? ofs_t'(fy_s4) - ofs_t'(ONE) : ofs_t'(fy_s4));
		assign oz  = (Slot[0] ? ofs_t'(fz_s4) - ofs_t'(ONE) : ofs_t'(fz_s4));
		assign oz2 = (Slot[1] ? ofs_t'(fz_s4) - ofs_t'(ONE) : ofs_t'(fz_s4));

		always_ff @(posedge clk) begin
			if (en.s5) begin
				corner_s5[k] <= (mode_s4 == MODE_3D) ? grad3(h_s4[k], ox, oy, oz)
					: grad2(h_s4[k], ox, oz2);
			end
		end
	end

endmodule

[src/gnd_blend.sv]
// Three lerp stages over the corner values, then saturation to Q3.16.
// Depends on gnd_pkg.
module gnd_blend import gnd_pkg::*; (
	input  logic      clk,
	input  stage_en_t en,
	input  logic      mode_s5,
	input  corner_t   corner_s5 [8],
	input  val_t      fu_s5,
	input  val_t      fv_s5,
	input  val_t      fw_s5,
	output corner_t   noise_s8
);

	val_t l_s6 [4];
	val_t fv_s6, fw_s6, fw_s7;
	logic mode_s6, mode_s7;
	val_t y0_s7, y1_s7;
	val_t res;

	// Stage six: blend along x; slot j is {y, z}
	for (genvar j = 0; j < 4; j++) begin : g_lx
		always_ff @(posedge clk) begin
			if (en.s6) begin
				l_s6[j] <= lerp(fu_s5, val_t'(corner_s5[j]), val_t'(corner_s5[j+4]));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s6) begin
			fv_s6   <= (mode_s5 == MODE_3D) ? fv_s5 : fw_s5;
			fw_s6   <= fw_s5;
			mode_s6 <= mode_s5;
		end
	end

	// Stage seven: blend along y (along z in 2D)
	always_ff @(posedge clk) begin
		if (en.s7) begin
			y0_s7   <= lerp(fv_s6, l_s6[0], l_s6[2]);
			y1_s7   <= lerp(fv_s6, l_s6[1], l_s6[3]);
			fw_s7   <= fw_s6;
			mode_s7 <= mode_s6;
		end
	end

	// Stage eight: blend along z in 3D, clamp
	assign res = (mode_s7 == MODE_3D) ? lerp(fw_s7, y0_s7, y1_s7) : y0_s7;

	always_ff @(posedge clk) begin
		if (en.s8) begin
			if (res > OUT_MAX)
				noise_s8 <= OutBits'(OUT_MAX);
			else if (res < OUT_MIN)
				noise_s8 <= OutBits'(OUT_MIN);
			else
				noise_s8 <= OutBits'(res);
		end
	end

endmodule

[src/gradient_noise_2d_3d.sv]
// Gradient noise block, two- and three-dimensional, in fixed point.
// Input beat: mode, coord_x, coord_y, coord_z (signed Q16.16), taken on
// in_valid high and in_stall low. Result beat: noise_value (signed Q3.16),
// taken on out_valid high and out_stall low.
// The seed register is written with seed_we; only its low 8 bits matter.
// Eight register stages: one split stage, three permutation ROM lookups in
// series, a gradient dot stage and three lerp multiplier stages (the fade
// multiplier chain runs alongside the lookups). A beat passes the stage
// registers in order from one to eight; its result then holds on the output
// register until taken. One beat enters every cycle while in_stall is low.
// Each stage advances when it is empty or the next stage advances, so
// bubbles close up; when the receiver stalls, the output holds and the
// pipeline fills behind it before in_stall rises. Nothing is dropped or
// repeated.
// Reset clears all valid bits and the seed; the ROM is constant.
// Depends on gnd_pkg, gnd_fade, gnd_hash and gnd_blend.
module gradient_noise_2d_3d import gnd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 seed_we,
	input  logic [31:0]          seed,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 mode,
	input  logic [CoordBits-1:0] coord_x,
	input  logic [CoordBits-1:0] coord_y,
	input  logic [CoordBits-1:0] coord_z,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [19:0]          noise_value
);

	cell_t     seed_q;
	stage_en_t en;
	logic [8:1] vld_q;
	logic      mode_s1, mode_s5;
	logic      mode_s2, mode_s3, mode_s4;
	cell_t     cx_s1, cy_s1, cz_s1;
	frac_t     fx_s1, fy_s1, fz_s1;
	val_t      fu_s5, fv_s5, fw_s5;
	corner_t   corner_s5 [8];
	corner_t   noise_s8;

	// Seed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			seed_q <= '0;
		else if (seed_we)
			seed_q <= seed[CellBits-1:0];
	end

	// Advance a stage when empty or when the next one advances
	always_comb begin
		en.s8 = !vld_q[8] || !out_stall;
		en.s7 = !vld_q[7] || en.s8;
		en.s6 = !vld_q[6] || en.s7;
		en.s5 = !vld_q[5] || en.s6;
		en.s4 = !vld_q[4] || en.s5;
		en.s3 = !vld_q[3] || en.s4;
		en.s2 = !vld_q[2] || en.s3;
		en.s1 = !vld_q[1] || en.s2;
	end

	assign in_stall  = !en.s1;
	assign out_valid = vld_q[8];

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en.s1) vld_q[1] <= in_valid;
			if (en.s2) vld_q[2] <= vld_q[1];
			if (en.s3) vld_q[3] <= vld_q[2];
			if (en.s4) vld_q[4] <= vld_q[3];
			if (en.s5) vld_q[5] <= vld_q[4];
			if (en.s6) vld_q[6] <= vld_q[5];
			if (en.s7) vld_q[7] <= vld_q[6];
			if (en.s8) vld_q[8] <= vld_q[7];
		end
	end

	// Stage one: split into seeded lattice cell and fraction
	always_ff @(posedge clk) begin
		if (en.s1) begin
			mode_s1 <= mode;
			cx_s1   <= coord_x[FracBits+CellBits-1:FracBits] + seed_q;
			cy_s1   <= coord_y[FracBits+CellBits-1:FracBits] + seed_q;
			cz_s1   <= coord_z[FracBits+CellBits-1:FracBits] + seed_q;
			fx_s1   <= coord_x[FracBits-1:0];
			fy_s1   <= coord_y[FracBits-1:0];
			fz_s1   <= coord_z[FracBits-1:0];
		end
	end

	// Carry the mode alongside the hash stages for the blend
	always_ff @(posedge clk) begin
		if (en.s2) mode_s2 <= mode_s1;
		if (en.s3) mode_s3 <= mode_s2;
		if (en.s4) mode_s4 <= mode_s3;
		if (en.s5) mode_s5 <= mode_s4;
	end

	gnd_fade u_fade_x (.clk(clk), .en(en), .frac_s1(fx_s1), .fade_s5(fu_s5));
	gnd_fade u_fade_y (.clk(clk), .en(en), .frac_s1(fy_s1), .fade_s5(fv_s5));
	gnd_fade u_fade_z (.clk(clk), .en(en), .frac_s1(fz_s1), .fade_s5(fw_s5));

	gnd_hash u_hash (
		.clk       (clk),
		.en        (en),
		.mode_s1   (mode_s1),
		.cx_s1     (cx_s1),
		.cy_s1     (cy_s1),
		.cz_s1     (cz_s1),
		.fx_s1     (fx_s1),
		.fy_s1     (fy_s1),
		.fz_s1     (fz_s1),
		.corner_s5 (corner_s5)
	);

	gnd_blend u_blend (
		.clk       (clk),
		.en        (en),
		.mode_s5   (mode_s5),
		.corner_s5 (corner_s5),
		.fu_s5     (fu_s5),
		.fv_s5     (fv_s5),
		.fw_s5     (fw_s5),
		.noise_s8  (noise_s8)
	);

	assign noise_value = noise_s8;

endmodule
